[rtl/svau_pkg.sv]
`timescale 1ns / 1ps

package svau_pkg;

	localparam int COORD_W  = 24;
	localparam int VEC_W    = COORD_W + 1;
	localparam int NRM_W    = 16;
	localparam int FRAC     = 24;
	localparam int UNIT_W   = FRAC + 2;
	localparam int ALPHA_W  = 8;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// normalization and square root
	localparam int SQ_W       = 2 * VEC_W;
	localparam int SUM_W      = SQ_W;
	localparam int NORM_W     = 62;
	localparam int K_W        = 5;
	localparam int ROOT_W     = NORM_W / 2;
	localparam int MK_W       = ROOT_W;
	localparam int SQRT_STEPS = ROOT_W;

	// quotient of the unit-vector divide, at most 2^FRAC
	localparam int Q_W       = FRAC + 1;
	localparam int DIV_STEPS = Q_W;

	// unit vector front end: magnitude/square, sum, two normalize stages, shift,
	// square root, divide, sign
	localparam int UNIT_LAT = 5 + SQRT_STEPS + DIV_STEPS + 1;

	localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [VEC_W-1:0]   vec_t;
	typedef logic signed [NRM_W-1:0]   normal_t;
	typedef logic signed [UNIT_W-1:0]  unit_t;

	localparam coord_t LIGHT_X_RST = -24'sd245760;
	localparam coord_t LIGHT_Y_RST = 24'sd506880;
	localparam coord_t LIGHT_Z_RST = 24'sd24576;
	localparam coord_t EYE_RST     = 24'sd0;

	typedef enum logic [2:0] {
		REG_LIGHT_X = 3'd0,
		REG_LIGHT_Y = 3'd1,
		REG_LIGHT_Z = 3'd2,
		REG_EYE_X   = 3'd3,
		REG_EYE_Y   = 3'd4,
		REG_EYE_Z   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		normal_t nx;
		normal_t ny;
		normal_t nz;
		logic    batch_end;
	} side_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} unit_stat_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic               batch_end;
	} result_t;

endpackage

[rtl/specular_vertex_alpha_unit.sv]
// Specular vertex alpha: Phong term per vertex, one transaction per clock.
// Pipeline: 1 input register, the unit-vector units (31 square-root and 25 divide
// stages among them), 8 shading stages and 1 output register. Throughput: one
// vertex per cycle while out_ready is high.
// Reset: arst_n clears all valid bits and loads the light/eye registers with
// their defaults; no clearing pass, in_ready is already high at reset release.
`timescale 1ns / 1ps

module specular_vertex_alpha_unit import svau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// vertex input
	input  logic               in_valid,
	output logic               in_ready,
	input  coord_t             vertex_x,
	input  coord_t             vertex_y,
	input  coord_t             vertex_z,
	input  normal_t            normal_x,
	input  normal_t            normal_y,
	input  normal_t            normal_z,
	input  logic               batch_end,
	// result output
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ALPHA_W-1:0] spec_alpha,
	output logic               batch_end_out
);

	coord_t light [3];
	coord_t eye [3];

	// Register file; writes complete in the access phase with no wait states.
	assign pready = 1'b1;

	svau_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.light   (light),
		.eye     (eye)
	);

	// Pipeline advance: the whole datapath moves together and holds only when
	// the output skid stage is full. That stage absorbs the one transaction in
	// flight when out_ready drops, so nothing is lost or repeated.
	logic ce;

	assign in_ready = ce;

	// Stage 1: register the light and view vectors and the sideband.
	logic  val_s1;
	vec_t  lv_s1 [3];
	vec_t  vv_s1 [3];
	side_t side_s1;
	coord_t pos_c [3];

	assign pos_c[0] = vertex_x;
	assign pos_c[1] = vertex_y;
	assign pos_c[2] = vertex_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
		end else if (ce) begin
			val_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				lv_s1[i] <= VEC_W'(light[i]) - VEC_W'(pos_c[i]);
				vv_s1[i] <= VEC_W'(eye[i]) - VEC_W'(pos_c[i]);
			end
			side_s1.nx        <= normal_x;
			side_s1.ny        <= normal_y;
			side_s1.nz        <= normal_z;
			side_s1.batch_end <= batch_end;
		end
	end

	// Two identical unit-vector pipelines, light and view, in lockstep.
	unit_stat_t stat_l, stat_v;
	unit_t      lu [3];
	unit_t      vu [3];

	svau_unit u_unit_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (val_s1),
		.v        (lv_s1),
		.stat     (stat_l),
		.u        (lu)
	);

	svau_unit u_unit_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (val_s1),
		.v        (vv_s1),
		.stat     (stat_v),
		.u        (vu)
	);

	// Delay the normal and batch flag to line up with the unit vectors.
	side_t side_dl_s [UNIT_LAT];

	always_ff @(posedge clk) begin
		if (ce) begin
			side_dl_s[0] <= side_s1;
			for (int j = 1; j < UNIT_LAT; j++) begin
				side_dl_s[j] <= side_dl_s[j-1];
			end
		end
	end

	// Reflection, cosine and fourth power. A zero-length light or view vector
	// forces alpha to zero.
	logic               sh_valid;
	logic [ALPHA_W-1:0] sh_alpha;
	logic               sh_batch;

	svau_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (stat_l.valid),
		.kill      (stat_l.zero || stat_v.zero),
		.lu        (lu),
		.vu        (vu),
		.side      (side_dl_s[UNIT_LAT-1]),
		.out_valid (sh_valid),
		.alpha     (sh_alpha),
		.batch_end (sh_batch)
	);

	// Output register plus skid entry.
	result_t sh_res, out_res;

	assign sh_res.alpha     = sh_alpha;
	assign sh_res.batch_end = sh_batch;

	svau_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sh_valid),
		.up_ready (ce),
		.up_data  (sh_res),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_res)
	);

	assign spec_alpha    = out_res.alpha;
	assign batch_end_out = out_res.batch_end;

`ifndef SYNTHESIS
	a_units_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		stat_l.valid == stat_v.valid)
		else $error("light and view unit pipelines out of step");

	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("pipeline stalled with no pending output transaction");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && out_ready) |=> (out_valid && in_ready))
		else $error("skid entry not moved to the output register");
`endif

endmodule

[rtl/svau_regs.sv]
`timescale 1ns / 1ps

module svau_regs import svau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output coord_t             light [3],
	output coord_t             eye [3]
);

	coord_t   light_q [3];
	coord_t   eye_q [3];
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q[0] <= LIGHT_X_RST;
			light_q[1] <= LIGHT_Y_RST;
			light_q[2] <= LIGHT_Z_RST;
			eye_q[0]   <= EYE_RST;
			eye_q[1]   <= EYE_RST;
			eye_q[2]   <= EYE_RST;
		end else if (wr_en) begin
			case (idx)
				REG_LIGHT_X: light_q[0] <= coord_t'(pwdata[COORD_W-1:0]);
				REG_LIGHT_Y: light_q[1] <= coord_t'(pwdata[COORD_W-1:0]);
				REG_LIGHT_Z: light_q[2] <= coord_t'(pwdata[COORD_W-1:0]);
				REG_EYE_X:   eye_q[0]   <= coord_t'(pwdata[COORD_W-1:0]);
				REG_EYE_Y:   eye_q[1]   <= coord_t'(pwdata[COORD_W-1:0]);
				REG_EYE_Z:   eye_q[2]   <= coord_t'(pwdata[COORD_W-1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LIGHT_X: prdata = {{(PDATA_W-COORD_W){1'b0}}, light_q[0]};
			REG_LIGHT_Y: prdata = {{(PDATA_W-COORD_W){1'b0}}, light_q[1]};
			REG_LIGHT_Z: prdata = {{(PDATA_W-COORD_W){1'b0}}, light_q[2]};
			REG_EYE_X:   prdata = {{(PDATA_W-COORD_W){1'b0}}, eye_q[0]};
			REG_EYE_Y:   prdata = {{(PDATA_W-COORD_W){1'b0}}, eye_q[1]};
			REG_EYE_Z:   prdata = {{(PDATA_W-COORD_W){1'b0}}, eye_q[2]};
			default:     prdata = '0;
		endcase
	end

	assign light = light_q;
	assign eye   = eye_q;

endmodule

[rtl/svau_unit.sv]
`timescale 1ns / 1ps

module svau_unit import svau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ce,
	input  logic       in_valid,
	input  vec_t       v [3],
	output unit_stat_t stat,
	output unit_t      u [3]
);

	// stage 1: magnitudes and squares
	logic             val_s1;
	logic [VEC_W-1:0] m_s1 [3];
	logic [2:0]       neg_s1;
	logic [SQ_W-1:0]  sq_s1 [3];
	logic [VEC_W-1:0] m_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_c[i] = v[i][VEC_W-1] ? VEC_W'(-v[i]) : VEC_W'(v[i]);
		end
	end

	// stage 2: sum of squares
	logic             val_s2;
	logic [VEC_W-1:0] m_s2 [3];
	logic [2:0]       neg_s2;
	logic [SUM_W-1:0] s_s2;

	// stages 3 and 4: normalize by even shifts
	logic              val_s3, val_s4;
	logic [VEC_W-1:0]  m_s3 [3];
	logic [VEC_W-1:0]  m_s4 [3];
	logic [2:0]        neg_s3, neg_s4;
	logic              zero_s3, zero_s4;
	logic [NORM_W-1:0] x_s3, x_s4;
	logic [K_W-1:0]    k_s3, k_s4;
	logic [NORM_W-1:0] xa_c, xb_c;
	logic [K_W-1:0]    ka_c, kb_c;

	always_comb begin
		xa_c = NORM_W'(s_s2);
		ka_c = '0;
		if (xa_c[NORM_W-1 -: 32] == '0) begin
			xa_c = xa_c << 32;
			ka_c = K_W'(ka_c + K_W'(16));
		end
		if (xa_c[NORM_W-1 -: 16] == '0) begin
			xa_c = xa_c << 16;
			ka_c = K_W'(ka_c + K_W'(8));
		end
	end

	always_comb begin
		xb_c = x_s3;
		kb_c = k_s3;
		if (xb_c[NORM_W-1 -: 8] == '0) begin
			xb_c = xb_c << 8;
			kb_c = K_W'(kb_c + K_W'(4));
		end
		if (xb_c[NORM_W-1 -: 4] == '0) begin
			xb_c = xb_c << 4;
			kb_c = K_W'(kb_c + K_W'(2));
		end
		if (xb_c[NORM_W-1 -: 2] == '0) begin
			xb_c = xb_c << 2;
			kb_c = K_W'(kb_c + K_W'(1));
		end
	end

	// stage 5: scaled magnitudes m << k
	logic              val_s5;
	logic [MK_W-1:0]   mk_s5 [3];
	logic [2:0]        neg_s5;
	logic              zero_s5;
	logic [NORM_W-1:0] x_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
		end else if (ce) begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
			val_s5 <= val_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				m_s1[i]   <= m_c[i];
				neg_s1[i] <= v[i][VEC_W-1];
				sq_s1[i]  <= SQ_W'(m_c[i]) * SQ_W'(m_c[i]);
			end
			m_s2   <= m_s1;
			neg_s2 <= neg_s1;
			s_s2   <= SUM_W'(sq_s1[0] + sq_s1[1] + sq_s1[2]);

			m_s3    <= m_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= (s_s2 == '0);
			x_s3    <= xa_c;
			k_s3    <= ka_c;

			m_s4    <= m_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			x_s4    <= xb_c;
			k_s4    <= kb_c;

			for (int i = 0; i < 3; i++) begin
				mk_s5[i] <= MK_W'(MK_W'(m_s4[i]) << k_s4);
			end
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			x_s5    <= x_s4;
		end
	end

	// square root, one result bit per stage; the index is the stage
	logic                val_sr [SQRT_STEPS];
	logic [ROOT_W+1:0]   rem_sr [SQRT_STEPS];
	logic [ROOT_W-1:0]   root_sr [SQRT_STEPS];
	logic [NORM_W-1:0]   x_sr [SQRT_STEPS];
	logic [MK_W-1:0]     mk_sr [SQRT_STEPS][3];
	logic [2:0]          neg_sr [SQRT_STEPS];
	logic                zero_sr [SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic              val_in;
		logic [ROOT_W+1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [NORM_W-1:0] x_in;
		logic [MK_W-1:0]   mk_in [3];
		logic [2:0]        neg_in;
		logic              zero_in;
		logic [ROOT_W+3:0] rem2, trial;

		if (j == 0) begin : g_first
			assign val_in  = val_s5;
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = x_s5;
			assign mk_in   = mk_s5;
			assign neg_in  = neg_s5;
			assign zero_in = zero_s5;
		end else begin : g_next
			assign val_in  = val_sr[j-1];
			assign rem_in  = rem_sr[j-1];
			assign root_in = root_sr[j-1];
			assign x_in    = x_sr[j-1];
			assign mk_in   = mk_sr[j-1];
			assign neg_in  = neg_sr[j-1];
			assign zero_in = zero_sr[j-1];
		end

		assign rem2  = {rem_in, x_in[NORM_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_sr[j] <= 1'b0;
			end else if (ce) begin
				val_sr[j] <= val_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				if (rem2 >= trial) begin
					rem_sr[j]  <= (ROOT_W+2)'(rem2 - trial);
					root_sr[j] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_sr[j]  <= rem2[ROOT_W+1:0];
					root_sr[j] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				x_sr[j]    <= x_in << 2;
				mk_sr[j]   <= mk_in;
				neg_sr[j]  <= neg_in;
				zero_sr[j] <= zero_in;
			end
		end
	end

	// restoring divide (m << k << FRAC) / root, one quotient bit per stage
	logic              val_dv [DIV_STEPS];
	logic [ROOT_W-1:0] rem_dv [DIV_STEPS][3];
	logic [Q_W-1:0]    q_dv [DIV_STEPS][3];
	logic [ROOT_W-1:0] r_dv [DIV_STEPS];
	logic [2:0]        neg_dv [DIV_STEPS];
	logic              zero_dv [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic              val_in;
		logic [ROOT_W-1:0] rem_in [3];
		logic [2:0]        bin;
		logic [Q_W-1:0]    q_in [3];
		logic [ROOT_W-1:0] r_in;
		logic [2:0]        neg_in;
		logic              zero_in;
		logic [ROOT_W:0]   rem2 [3];

		if (j == 0) begin : g_first
			assign val_in  = val_sr[SQRT_STEPS-1];
			assign r_in    = root_sr[SQRT_STEPS-1];
			assign neg_in  = neg_sr[SQRT_STEPS-1];
			assign zero_in = zero_sr[SQRT_STEPS-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = ROOT_W'(mk_sr[SQRT_STEPS-1][i] >> 1);
				assign bin[i]    = mk_sr[SQRT_STEPS-1][i][0];
				assign q_in[i]   = '0;
			end
		end else begin : g_next
			assign val_in  = val_dv[j-1];
			assign r_in    = r_dv[j-1];
			assign neg_in  = neg_dv[j-1];
			assign zero_in = zero_dv[j-1];
			assign rem_in  = rem_dv[j-1];
			assign bin     = '0;
			assign q_in    = q_dv[j-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem2[i] = {rem_in[i], bin[i]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				val_dv[j] <= 1'b0;
			end else if (ce) begin
				val_dv[j] <= val_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				for (int i = 0; i < 3; i++) begin
					if (rem2[i] >= {1'b0, r_in}) begin
						rem_dv[j][i] <= ROOT_W'(rem2[i] - {1'b0, r_in});
						q_dv[j][i]   <= {q_in[i][Q_W-2:0], 1'b1};
					end else begin
						rem_dv[j][i] <= rem2[i][ROOT_W-1:0];
						q_dv[j][i]   <= {q_in[i][Q_W-2:0], 1'b0};
					end
				end
				r_dv[j]    <= r_in;
				neg_dv[j]  <= neg_in;
				zero_dv[j] <= zero_in;
			end
		end
	end

	// output stage: restore sign
	logic  val_so;
	logic  zero_so;
	unit_t u_so [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_so <= 1'b0;
		end else if (ce) begin
			val_so <= val_dv[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_so <= zero_dv[DIV_STEPS-1];
			for (int i = 0; i < 3; i++) begin
				u_so[i] <= neg_dv[DIV_STEPS-1][i] ? -UNIT_W'(q_dv[DIV_STEPS-1][i])
				                                  : UNIT_W'(q_dv[DIV_STEPS-1][i]);
			end
		end
	end

	assign stat.valid = val_so;
	assign stat.zero  = zero_so;
	assign u          = u_so;

endmodule

[rtl/svau_shade.sv]
`timescale 1ns / 1ps

module svau_shade import svau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ce,
	input  logic               in_valid,
	input  logic               kill,
	input  unit_t              lu [3],
	input  unit_t              vu [3],
	input  side_t              side,
	output logic               out_valid,
	output logic [ALPHA_W-1:0] alpha,
	output logic               batch_end
);

	localparam int P1_W  = UNIT_W + NRM_W;
	localparam int A1_W  = P1_W + 2;
	localparam int D_W   = A1_W - 14;
	localparam int T_W   = D_W + NRM_W + 1;
	localparam int RV_W  = 32;
	localparam int P2_W  = RV_W + UNIT_W;
	localparam int A2_W  = P2_W + 2;
	localparam int C_W   = A2_W - FRAC;
	localparam int CF_W  = FRAC;

	normal_t n_c [3];
	assign n_c[0] = side.nx;
	assign n_c[1] = side.ny;
	assign n_c[2] = side.nz;

	logic val_s1, val_s2, val_s3, val_s4, val_s5, val_s6, val_s7, val_s8;
	logic kill_s1, kill_s2, kill_s3, kill_s4;
	logic be_s1, be_s2, be_s3, be_s4, be_s5, be_s6, be_s7, be_s8;

	logic signed [P1_W-1:0] p_s1 [3];
	normal_t                n_s1 [3];
	normal_t                n_s2 [3];
	unit_t                  lu_s1 [3];
	unit_t                  lu_s2 [3];
	unit_t                  vu_s1 [3];
	unit_t                  vu_s2 [3];
	unit_t                  vu_s3 [3];
	logic signed [D_W-1:0]  d_s2;
	logic signed [RV_W-1:0] rv_s3 [3];
	logic signed [P2_W-1:0] q_s4 [3];

	logic                   zero_s5, sat_s5, zero_s6, sat_s6, zero_s7, sat_s7;
	logic [CF_W-1:0]        c_s5, c2_s6, c4_s7;
	logic [ALPHA_W-1:0]     alpha_s8;

	logic signed [A1_W-1:0] a1_c;
	logic signed [T_W-1:0]  t_c [3];
	logic signed [T_W-1:0]  ts_c [3];
	logic signed [A2_W-1:0] a2_c;
	logic signed [C_W-1:0]  c_c;
	logic [2*CF_W-1:0]      c2_c, c4_c;
	logic [2*CF_W-1:0]      a_c;

	always_comb begin
		a1_c = A1_W'(p_s1[0]) + A1_W'(p_s1[1]) + A1_W'(p_s1[2]);
		for (int i = 0; i < 3; i++) begin
			t_c[i]  = (T_W'(d_s2) * T_W'(n_s2[i])) <<< 1;
			ts_c[i] = t_c[i] >>> 14;
		end
		a2_c = A2_W'(q_s4[0]) + A2_W'(q_s4[1]) + A2_W'(q_s4[2]);
		c_c  = C_W'(a2_c >>> FRAC);
		c2_c = (2*CF_W)'(c_s5) * (2*CF_W)'(c_s5);
		c4_c = (2*CF_W)'(c2_s6) * (2*CF_W)'(c2_s6);
		a_c  = (2*CF_W)'(c4_s7) * (2*CF_W)'(ALPHA_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1 <= 1'b0;
			val_s2 <= 1'b0;
			val_s3 <= 1'b0;
			val_s4 <= 1'b0;
			val_s5 <= 1'b0;
			val_s6 <= 1'b0;
			val_s7 <= 1'b0;
			val_s8 <= 1'b0;
		end else if (ce) begin
			val_s1 <= in_valid;
			val_s2 <= val_s1;
			val_s3 <= val_s2;
			val_s4 <= val_s3;
			val_s5 <= val_s4;
			val_s6 <= val_s5;
			val_s7 <= val_s6;
			val_s8 <= val_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// N.L products
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= P1_W'(lu[i]) * P1_W'(n_c[i]);
			end
			n_s1    <= n_c;
			lu_s1   <= lu;
			vu_s1   <= vu;
			kill_s1 <= kill;
			be_s1   <= side.batch_end;

			d_s2    <= D_W'(a1_c >>> 14);
			n_s2    <= n_s1;
			lu_s2   <= lu_s1;
			vu_s2   <= vu_s1;
			kill_s2 <= kill_s1;
			be_s2   <= be_s1;

			// reflect: R = 2dN - L
			for (int i = 0; i < 3; i++) begin
				rv_s3[i] <= RV_W'(ts_c[i]) - RV_W'(lu_s2[i]);
			end
			vu_s3   <= vu_s2;
			kill_s3 <= kill_s2;
			be_s3   <= be_s2;

			for (int i = 0; i < 3; i++) begin
				q_s4[i] <= P2_W'(rv_s3[i]) * P2_W'(vu_s3[i]);
			end
			kill_s4 <= kill_s3;
			be_s4   <= be_s3;

			// classify the cosine
			zero_s5 <= kill_s4 || c_c[C_W-1];
			sat_s5  <= c_c[C_W-2:CF_W] != '0;
			c_s5    <= c_c[CF_W-1:0];
			be_s5   <= be_s4;

			c2_s6   <= c2_c[2*CF_W-1:CF_W];
			zero_s6 <= zero_s5;
			sat_s6  <= sat_s5;
			be_s6   <= be_s5;

			c4_s7   <= c4_c[2*CF_W-1:CF_W];
			zero_s7 <= zero_s6;
			sat_s7  <= sat_s6;
			be_s7   <= be_s6;

			if (zero_s7) begin
				alpha_s8 <= '0;
			end else if (sat_s7) begin
				alpha_s8 <= ALPHA_MAX;
			end else begin
				alpha_s8 <= a_c[CF_W +: ALPHA_W];
			end
			be_s8 <= be_s7;
		end
	end

	assign out_valid = val_s8;
	assign alpha     = alpha_s8;
	assign batch_end = be_s8;

endmodule

[rtl/svau_skid.sv]
`timescale 1ns / 1ps

module svau_skid import svau_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    up_valid,
	output logic    up_ready,
	input  result_t up_data,
	output logic    dn_valid,
	input  logic    dn_ready,
	output result_t dn_data
);

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    drain;

	assign up_ready = !skid_valid_q;
	assign drain    = dn_ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || up_valid;
			skid_valid_q <= 1'b0;
		end else if (up_valid && up_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_valid_q ? skid_q : up_data;
		end else if (up_valid && up_ready) begin
			skid_q <= up_data;
		end
	end

	assign dn_valid = out_valid_q;
	assign dn_data  = out_q;

endmodule

[tb/specular_vertex_alpha_unit_tb.sv]
`timescale 1ns / 1ps

module specular_vertex_alpha_unit_tb;
	import svau_pkg::*;

	localparam int LATENCY = 72;

	typedef struct {
		coord_t  vx, vy, vz;
		normal_t nx, ny, nz;
		logic    bend;
	} vertex_t;

	typedef struct {
		logic [ALPHA_W-1:0] alpha;
		logic               bend;
	} shade_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	coord_t             vertex_x = '0, vertex_y = '0, vertex_z = '0;
	normal_t            normal_x = '0, normal_y = '0, normal_z = '0;
	logic               batch_end = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ALPHA_W-1:0] spec_alpha;
	logic               batch_end_out;

	specular_vertex_alpha_unit uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the light and eye registers
	coord_t light_pos[3];
	coord_t eye_pos[3];

	vertex_t pending_vertices[$];
	shade_t  expected_shades[$];
	int      mismatches = 0;
	bit      calm = 1'b0;      // no idling on either side
	bit      hold_off = 1'b0;  // receiver stalls while this is set
	bit      stim_done = 1'b0;

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// scale to unit length in Q.24; returns 0 for a zero vector
	function automatic bit to_unit(input longint v[3], output longint u[3]);
		logic [63:0] s, r, m, q;
		int k;
		s = 0;
		k = 0;
		for (int i = 0; i < 3; i++) begin
			m = v[i] < 0 ? -v[i] : v[i];
			s += m * m;
		end
		if (s == 0) return 1'b0;
		while (s < (64'd1 << 60)) begin
			s <<= 2;
			k++;
		end
		r = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			m = v[i] < 0 ? -v[i] : v[i];
			q = ((m << k) << FRAC) / r;
			u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic shade_t specular_of(vertex_t t);
		longint pos[3], nrm[3], lv[3], vv[3], lu[3], vu[3], rv[3];
		longint acc, d, c;
		logic [63:0] c1, c2, c4, a;
		shade_t res;
		pos = '{t.vx, t.vy, t.vz};
		nrm = '{t.nx, t.ny, t.nz};
		res.alpha = 0;
		res.bend = t.bend;
		for (int i = 0; i < 3; i++) begin
			lv[i] = longint'(light_pos[i]) - pos[i];
			vv[i] = longint'(eye_pos[i]) - pos[i];
		end
		if (to_unit(lv, lu) && to_unit(vv, vu)) begin
			acc = 0;
			for (int i = 0; i < 3; i++) acc += nrm[i] * lu[i];
			d = acc >>> 14;
			for (int i = 0; i < 3; i++) rv[i] = ((2 * d * nrm[i]) >>> 14) - lu[i];
			acc = 0;
			for (int i = 0; i < 3; i++) acc += rv[i] * vu[i];
			c = acc >>> FRAC;
			if (c < 0) begin
				res.alpha = 0;
			end else if (c >= (longint'(1) << FRAC)) begin
				res.alpha = ALPHA_MAX;
			end else begin
				c1 = c;
				c2 = (c1 * c1) >> FRAC;
				c4 = (c2 * c2) >> FRAC;
				a = (c4 * 255) >> FRAC;
				res.alpha = a > 255 ? ALPHA_MAX : a[7:0];
			end
		end
		return res;
	endfunction

	// write one register over the APB port and mirror it in the predictor
	task automatic write_reg(reg_idx_t idx, coord_t value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * idx);
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx <= REG_LIGHT_Z) light_pos[idx] = value;
		else eye_pos[idx - REG_EYE_X] = value;
	endtask

	task automatic set_scene(coord_t lx, coord_t ly, coord_t lz, coord_t ex, coord_t ey,
			coord_t ez);
		write_reg(REG_LIGHT_X, lx);
		write_reg(REG_LIGHT_Y, ly);
		write_reg(REG_LIGHT_Z, lz);
		write_reg(REG_EYE_X, ex);
		write_reg(REG_EYE_Y, ey);
		write_reg(REG_EYE_Z, ez);
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		while (pending_vertices.size() != 0 || expected_shades.size() != 0 || in_valid)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic queue_vertex(coord_t vx, coord_t vy, coord_t vz, normal_t nx, normal_t ny,
			normal_t nz, logic bend);
		vertex_t t;
		t.vx = vx; t.vy = vy; t.vz = vz;
		t.nx = nx; t.ny = ny; t.nz = nz;
		t.bend = bend;
		pending_vertices.push_back(t);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 8191)) - 4096);
			2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
			default: return coord_t'($signed($urandom_range(0, 1048575)) - 524288);
		endcase
	endfunction

	function automatic normal_t rand_normal();
		case ($urandom_range(0, 3))
			0: return normal_t'($urandom);
			1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			default: return normal_t'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// roughly unit normal built from a random direction, or random normal components;
	task automatic queue_random_vertex();
		normal_t n[3];
		real x, y, z, len;
		if ($urandom_range(0, 9) < 7) begin
			x = $signed($urandom_range(0, 2000)) - 1000;
			y = $signed($urandom_range(0, 2000)) - 1000;
			z = $signed($urandom_range(0, 2000)) - 1000;
			len = $sqrt(x * x + y * y + z * z) + 1e-3;
			n[0] = normal_t'($rtoi(x / len * 16384.0));
			n[1] = normal_t'($rtoi(y / len * 16384.0));
			n[2] = normal_t'($rtoi(z / len * 16384.0));
		end else begin
			n[0] = rand_normal();
			n[1] = rand_normal();
			n[2] = rand_normal();
		end
		if ($urandom_range(0, 19) == 0)
			queue_vertex(light_pos[0], light_pos[1], light_pos[2], n[0], n[1], n[2],
				$urandom_range(0, 1));
		else if ($urandom_range(0, 19) == 0)
			queue_vertex(eye_pos[0], eye_pos[1], eye_pos[2], n[0], n[1], n[2],
				$urandom_range(0, 1));
		else
			queue_vertex(rand_coord(), rand_coord(), rand_coord(), n[0], n[1], n[2],
				$urandom_range(0, 7) == 0);
	endtask

	// sender: pop the next vertex and hold it until accepted
	always @(posedge clk) begin
		if (in_valid && in_ready) expected_shades.push_back(specular_of('{vertex_x, vertex_y,
			vertex_z, normal_x, normal_y, normal_z, batch_end}));
		if (!in_valid || in_ready) begin
			if (arst_n && pending_vertices.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
				vertex_t t;
				t = pending_vertices.pop_front();
				in_valid <= 1'b1;
				vertex_x <= t.vx; vertex_y <= t.vy; vertex_z <= t.vz;
				normal_x <= t.nx; normal_y <= t.ny; normal_z <= t.nz;
				batch_end <= t.bend;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_shades.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result alpha=%0d", spec_alpha);
			end else begin
				shade_t e;
				e = expected_shades.pop_front();
				if (e.alpha !== spec_alpha || e.bend !== batch_end_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected alpha=%0d end=%0b, got alpha=%0d end=%0b",
							e.alpha, e.bend, spec_alpha, batch_end_out);
				end
			end
		end
		out_ready <= arst_n && !hold_off && (calm || $urandom_range(0, 99) >= 9);
	end

	// long receiver stall in the no-idle phase, while the sender keeps offering,
	// so the pipeline fills and backs up the input
	initial begin
		wait (stim_done == 1'b0 && calm && pending_vertices.size() > 200);
		repeat (20) @(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#20ms;
		$display("specular_vertex_alpha_unit_tb failed");
		$finish;
	end

	initial begin
		light_pos = '{LIGHT_X_RST, LIGHT_Y_RST, LIGHT_Z_RST};
		eye_pos = '{EYE_RST, EYE_RST, EYE_RST};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset scene, extremes, light and eye coincidences, odd normals
		queue_vertex(0, 0, 0, 0, 0, 16384, 0);
		queue_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16384, 0, 0, 1);
		queue_vertex(24'sh800000, 24'sh800000, 24'sh800000, -16384, -16384, -16384, 0);
		queue_vertex(-245760, 506880, 24576, 0, 16384, 0, 1);
		queue_vertex(100, 200, -300, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
		queue_vertex(-100, 50, 7, 16'sh8000, 16'sh8000, 16'sh8000, 1);
		queue_vertex(-480, 990, 48, 0, 0, 0, 0);
		queue_vertex(0, -256, 0, 0, 16384, 0, 0);
		queue_vertex(24'sh7FFFFF, 24'sh800000, 0, 11585, 11585, 0, 1);
		queue_vertex(1, 1, 1, -16384, 16384, -16384, 0);
		drain();

		// light and eye on the same axis, vertex on a mirror normal
		set_scene(0, 2560, 0, 0, 2560, 0);
		queue_vertex(0, 0, 0, 0, 16384, 0, 0);
		queue_vertex(0, 2560, 0, 0, 16384, 0, 1);
		queue_vertex(0, 0, 0, 0, -16384, 0, 0);
		queue_vertex(0, 0, 0, 0, 32767, 0, 0);
		drain();

		set_scene(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000,
			24'sh800000);
		queue_vertex(0, 0, 0, 9459, 9459, 9459, 0);
		queue_vertex(24'sh800000, 24'sh800000, 24'sh800000, 9459, 9459, 9459, 1);
		queue_vertex(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 16384, 0);
		for (int i = 0; i < 400; i++) queue_random_vertex();
		drain();

		// random scenes; the second one runs with no idling and the long stall
		for (int phase = 0; phase < 4; phase++) begin
			set_scene(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord());
			calm = (phase == 1);
			for (int i = 0; i < 300; i++) queue_random_vertex();
			drain();
		end
		calm = 1'b0;

		set_scene(24'sh800000, 0, 24'sh7FFFFF, 0, 24'sh7FFFFF, 24'sh800000);
		for (int i = 0; i < 100; i++) queue_random_vertex();
		drain();
		stim_done = 1'b1;

		if (mismatches == 0 && expected_shades.size() == 0)
			$display("specular_vertex_alpha_unit_tb passed");
		else
			$display("specular_vertex_alpha_unit_tb failed");
		$finish;
	end

endmodule

[sim.f]
rtl/svau_pkg.sv
rtl/svau_regs.sv
rtl/svau_unit.sv
rtl/svau_shade.sv
rtl/svau_skid.sv
rtl/specular_vertex_alpha_unit.sv
tb/specular_vertex_alpha_unit_tb.sv
